// ===== design/dmc_pkg.sv =====
package dmc_pkg;

    localparam int unsigned RUN_W   = 8;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned PHASE_W = 2;

    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;

    localparam logic [RUN_W-1:0]  ENTER_TICKS_RST    = RUN_W'(8);
    localparam logic [RUN_W-1:0]  LEAVE_TICKS_RST    = RUN_W'(8);
    localparam logic [RUN_W-1:0]  CONFIRM_TICKS_RST  = RUN_W'(40);
    localparam logic [TIME_W-1:0] MIN_INTERVAL_RST   = TIME_W'(250);
    localparam logic [TIME_W-1:0] COOLDOWN_TICKS_RST = TIME_W'(600);

    typedef enum logic [2:0] {
        REG_ENTER_TICKS    = 3'd0,
        REG_LEAVE_TICKS    = 3'd1,
        REG_CONFIRM_TICKS  = 3'd2,
        REG_MIN_INTERVAL   = 3'd3,
        REG_COOLDOWN_TICKS = 3'd4
    } t_reg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_REARM = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT_LOW   = 2'd0,
        PH_WAIT_LEAVE = 2'd1,
        PH_WAIT_HIGH  = 2'd2,
        PH_COUNTED    = 2'd3
    } t_phase;

    typedef struct packed {
        logic [RUN_W-1:0]  enter_ticks;
        logic [RUN_W-1:0]  leave_ticks;
        logic [RUN_W-1:0]  confirm_ticks;
        logic [TIME_W-1:0] min_interval;
        logic [TIME_W-1:0] cooldown_ticks;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            left_sensor;
        logic            right_sensor;
        logic            inhibit;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               counted;
        logic               rejected;
        logic               frozen;
        logic [PHASE_W-1:0] qualifier_phase;
    } t_res;

endpackage

// ===== design/dmc_in_if.sv =====
interface dmc_in_if;
    logic                       valid;
    logic                       ready;
    logic [dmc_pkg::OP_W-1:0]   op;
    logic                       left_sensor;
    logic                       right_sensor;
    logic                       inhibit;

    modport source (output valid, output op, output left_sensor, output right_sensor,
                    output inhibit, input ready);
    modport sink (input valid, input op, input left_sensor, input right_sensor,
                  input inhibit, output ready);
endinterface

// ===== design/dmc_out_if.sv =====
interface dmc_out_if;
    logic                          valid;
    logic                          ready;
    logic [dmc_pkg::COUNT_W-1:0]   count;
    logic                          counted;
    logic                          rejected;
    logic                          frozen;
    logic [dmc_pkg::PHASE_W-1:0]   qualifier_phase;

    modport source (output valid, output count, output counted, output rejected,
                    output frozen, output qualifier_phase, input ready);
    modport sink (input valid, input count, input counted, input rejected,
                  input frozen, input qualifier_phase, output ready);
endinterface

// ===== design/debounced_marker_counter.sv =====
// Marker crossing counter with sensor debounce. Each input word is one 1 ms tick
// (or a rearm/clear command) and yields exactly one result word in the cycle after it
// is taken. One word is accepted every clock cycle: the whole per-tick update of
// the qualifier, cooldown timer and tick clock is one combinational step on the
// state registers, and the result register lets the next word in while a result
// waits; input ready drops only when the result register is full and the sink
// stalls. Registers on the APB port (byte address 4*index): enter_ticks,
// leave_ticks, confirm_ticks, min_interval, cooldown_ticks; write them only while
// no result is outstanding.
module debounced_marker_counter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dmc_in_if.sink                            i_in,
    dmc_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dmc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dmc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dmc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    dmc_pkg::t_cfg  w_cfg;
    dmc_pkg::t_item w_item;
    dmc_pkg::t_res  w_res;
    dmc_pkg::t_res  r_res;
    logic           r_out_valid;
    logic           w_accept;

    dmc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_item.op           = i_in.op;
    assign w_item.left_sensor  = i_in.left_sensor;
    assign w_item.right_sensor = i_in.right_sensor;
    assign w_item.inhibit      = i_in.inhibit;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    dmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.count           = r_res.count;
    assign o_out.counted         = r_res.counted;
    assign o_out.rejected        = r_res.rejected;
    assign o_out.frozen          = r_res.frozen;
    assign o_out.qualifier_phase = r_res.qualifier_phase;

endmodule

// ===== design/dmc_cfg.sv =====
module dmc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dmc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dmc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dmc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output dmc_pkg::t_cfg                     o_cfg
);

    dmc_pkg::t_cfg     r_cfg;
    dmc_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = dmc_pkg::t_reg_idx'(paddr[dmc_pkg::APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enter_ticks    <= dmc_pkg::ENTER_TICKS_RST;
            r_cfg.leave_ticks    <= dmc_pkg::LEAVE_TICKS_RST;
            r_cfg.confirm_ticks  <= dmc_pkg::CONFIRM_TICKS_RST;
            r_cfg.min_interval   <= dmc_pkg::MIN_INTERVAL_RST;
            r_cfg.cooldown_ticks <= dmc_pkg::COOLDOWN_TICKS_RST;
        end else if (w_wr) begin
            case (w_idx)
                dmc_pkg::REG_ENTER_TICKS:
                    r_cfg.enter_ticks <= pwdata[dmc_pkg::RUN_W-1:0];
                dmc_pkg::REG_LEAVE_TICKS:
                    r_cfg.leave_ticks <= pwdata[dmc_pkg::RUN_W-1:0];
                dmc_pkg::REG_CONFIRM_TICKS:
                    r_cfg.confirm_ticks <= pwdata[dmc_pkg::RUN_W-1:0];
                dmc_pkg::REG_MIN_INTERVAL:
                    r_cfg.min_interval <= pwdata[dmc_pkg::TIME_W-1:0];
                dmc_pkg::REG_COOLDOWN_TICKS:
                    r_cfg.cooldown_ticks <= pwdata[dmc_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            dmc_pkg::REG_ENTER_TICKS:
                prdata = dmc_pkg::APB_DATA_W'(r_cfg.enter_ticks);
            dmc_pkg::REG_LEAVE_TICKS:
                prdata = dmc_pkg::APB_DATA_W'(r_cfg.leave_ticks);
            dmc_pkg::REG_CONFIRM_TICKS:
                prdata = dmc_pkg::APB_DATA_W'(r_cfg.confirm_ticks);
            dmc_pkg::REG_MIN_INTERVAL:
                prdata = dmc_pkg::APB_DATA_W'(r_cfg.min_interval);
            dmc_pkg::REG_COOLDOWN_TICKS:
                prdata = dmc_pkg::APB_DATA_W'(r_cfg.cooldown_ticks);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== design/dmc_core.sv =====
module dmc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  dmc_pkg::t_item i_item,
    input  dmc_pkg::t_cfg  i_cfg,
    output dmc_pkg::t_res  o_res
);

    dmc_pkg::t_phase                 r_phase,       n_phase;
    logic [dmc_pkg::RUN_W-1:0]       r_enter_run,   n_enter_run;
    logic [dmc_pkg::RUN_W-1:0]       r_leave_run,   n_leave_run;
    logic [dmc_pkg::RUN_W-1:0]       r_confirm_run, n_confirm_run;
    logic                            r_cd_on,       n_cd_on;
    logic [dmc_pkg::TIME_W-1:0]      r_cd_elapsed,  n_cd_elapsed;
    logic [dmc_pkg::TIME_W-1:0]      r_tick_now,    n_tick_now;
    logic [dmc_pkg::TIME_W-1:0]      r_last_count,  n_last_count;
    logic [dmc_pkg::COUNT_W-1:0]     r_total,       n_total;
    logic                            n_counted;
    logic                            n_rejected;

    logic                            w_both_low;
    logic                            w_both_high;
    logic [dmc_pkg::TIME_W-1:0]      w_gap;

    assign w_both_low  = !i_item.left_sensor && !i_item.right_sensor;
    assign w_both_high = i_item.left_sensor && i_item.right_sensor;

    always_comb begin
        n_phase       = r_phase;
        n_enter_run   = r_enter_run;
        n_leave_run   = r_leave_run;
        n_confirm_run = r_confirm_run;
        n_cd_on       = r_cd_on;
        n_cd_elapsed  = r_cd_elapsed;
        n_tick_now    = r_tick_now;
        n_last_count  = r_last_count;
        n_total       = r_total;
        n_counted     = 1'b0;
        n_rejected    = 1'b0;
        w_gap         = '0;

        case (dmc_pkg::t_op'(i_item.op))
            dmc_pkg::OP_REARM, dmc_pkg::OP_CLEAR: begin
                n_cd_on       = 1'b0;
                n_phase       = dmc_pkg::PH_WAIT_LOW;
                n_enter_run   = '0;
                n_leave_run   = '0;
                n_confirm_run = '0;
                if (dmc_pkg::t_op'(i_item.op) == dmc_pkg::OP_CLEAR) begin
                    n_total = '0;
                end
            end
            dmc_pkg::OP_TICK: begin
                if (r_cd_on && (r_cd_elapsed != '1)) begin
                    n_cd_elapsed = r_cd_elapsed + 1'b1;
                end
                n_tick_now = r_tick_now + 1'b1;
                w_gap      = n_tick_now - r_last_count;

                if (!r_cd_on && !i_item.inhibit) begin
                    unique case (r_phase)
                        dmc_pkg::PH_WAIT_LOW: begin
                            if (w_both_low) begin
                                n_enter_run = r_enter_run + 1'b1;
                                if (n_enter_run >= i_cfg.enter_ticks) begin
                                    n_phase     = dmc_pkg::PH_WAIT_LEAVE;
                                    n_enter_run = '0;
                                end
                            end else begin
                                n_enter_run = '0;
                            end
                        end
                        dmc_pkg::PH_WAIT_LEAVE: begin
                            if (!w_both_low) begin
                                n_leave_run = r_leave_run + 1'b1;
                                if (n_leave_run >= i_cfg.leave_ticks) begin
                                    n_phase       = dmc_pkg::PH_WAIT_HIGH;
                                    n_leave_run   = '0;
                                    n_confirm_run = '0;
                                end
                            end else begin
                                n_leave_run = '0;
                            end
                        end
                        dmc_pkg::PH_WAIT_HIGH: begin
                            if (w_both_high) begin
                                n_confirm_run = r_confirm_run + 1'b1;
                                if (n_confirm_run >= i_cfg.confirm_ticks) begin
                                    n_confirm_run = '0;
                                    if (w_gap < i_cfg.min_interval) begin
                                        n_phase     = dmc_pkg::PH_WAIT_LOW;
                                        n_enter_run = '0;
                                        n_leave_run = '0;
                                        n_rejected  = 1'b1;
                                    end else begin
                                        n_last_count = n_tick_now;
                                        n_total      = r_total + 1'b1;
                                        n_phase      = dmc_pkg::PH_COUNTED;
                                        n_counted    = 1'b1;
                                    end
                                    n_cd_on      = 1'b1;
                                    n_cd_elapsed = '0;
                                end
                            end else begin
                                n_confirm_run = '0;
                            end
                        end
                        dmc_pkg::PH_COUNTED: ;
                    endcase
                end

                if (n_cd_on && (n_cd_elapsed >= i_cfg.cooldown_ticks)) begin
                    n_cd_on     = 1'b0;
                    n_phase     = dmc_pkg::PH_WAIT_LOW;
                    n_enter_run = '0;
                    n_leave_run = '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.count           = n_total;
        o_res.counted         = n_counted;
        o_res.rejected        = n_rejected;
        o_res.frozen          = n_cd_on;
        o_res.qualifier_phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= dmc_pkg::PH_WAIT_LOW;
            r_enter_run   <= '0;
            r_leave_run   <= '0;
            r_confirm_run <= '0;
            r_cd_on       <= 1'b0;
            r_cd_elapsed  <= '0;
            r_tick_now    <= '0;
            r_last_count  <= '0;
            r_total       <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_enter_run   <= n_enter_run;
            r_leave_run   <= n_leave_run;
            r_confirm_run <= n_confirm_run;
            r_cd_on       <= n_cd_on;
            r_cd_elapsed  <= n_cd_elapsed;
            r_tick_now    <= n_tick_now;
            r_last_count  <= n_last_count;
            r_total       <= n_total;
        end
    end

endmodule
